// ----- rtl/core/twgmc_pkg.sv -----
package twgmc_pkg;

    localparam int CELL_W      = 8;
    localparam int TOTAL_W     = 15;
    localparam int ROW_COUNT_W = 7;
    localparam int COL_COUNT_W = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 7'd64;
    localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_A_READ,
        ST_A_SAVE,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic a_read;
        logic a_save;
        logic ph0;
        logic ph1;
        logic ph2;
        logic ph3;
        logic preload;
    } cmd_t;

    typedef struct packed {
        logic last_b;
        logic last_a;
        logic last_row;
    } status_t;

endpackage

// ----- rtl/core/twgmc_ram.sv -----
module twgmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/twgmc_ctrl.sv -----
module twgmc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last_cell,
    input  twgmc_pkg::status_t  status,
    output twgmc_pkg::cmd_t     cmd,
    output logic                busy,
    output logic                done
);

    import twgmc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   preload_reg;
    logic   preload_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            preload_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            preload_reg <= preload_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        preload_next = preload_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_cell)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_A_READ;
            end
            ST_A_READ:
            begin
                state_next = ST_A_SAVE;
            end
            ST_A_SAVE:
            begin
                // column 0 of the previous row is fetched before the first pair
                preload_next = 1'b1;
                state_next   = ST_P0;
            end
            ST_P0:
            begin
                state_next = ST_P1;
            end
            ST_P1:
            begin
                state_next = ST_P2;
            end
            ST_P2:
            begin
                state_next = ST_P3;
            end
            ST_P3:
            begin
                preload_next = 1'b0;
                if (preload_reg || !status.last_b)
                begin
                    state_next = ST_P0;
                end
                else if (!status.last_a || !status.last_row)
                begin
                    state_next = ST_A_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.preload = preload_reg;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_IDLE:   busy       = 1'b0;
            ST_START:  cmd.init   = 1'b1;
            ST_A_READ: cmd.a_read = 1'b1;
            ST_A_SAVE: cmd.a_save = 1'b1;
            ST_P0:     cmd.ph0    = 1'b1;
            ST_P1:     cmd.ph1    = 1'b1;
            ST_P2:     cmd.ph2    = 1'b1;
            ST_P3:     cmd.ph3    = 1'b1;
            ST_DONE:   done       = 1'b1;
            default:   busy       = 1'b1;
        endcase
    end

endmodule

// ----- rtl/core/twgmc_dpath.sv -----
module twgmc_dpath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  twgmc_pkg::cmd_t                         cmd,
    input  logic [twgmc_pkg::ROW_COUNT_W-1:0]       row_count,
    input  logic [twgmc_pkg::COL_COUNT_W-1:0]       col_count,
    input  logic [twgmc_pkg::CELL_W-1:0]            cell_value,
    input  logic                                    last_cell,
    output twgmc_pkg::status_t                      status,
    output logic [twgmc_pkg::TOTAL_W-1:0]           best_total
);

    import twgmc_pkg::*;

    localparam int RIDX_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNT_W      = RIDX_W + 1;
    localparam int CIDX_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCNT_W      = CIDX_W + 1;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int GADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LOAD_W      = GADDR_W + 1;
    localparam int SADDR_W     = 2 * CIDX_W + 1;
    localparam int SCORE_DEPTH = 1 << SADDR_W;
    localparam int SUM_W       = $clog2(2 * ((1 << CELL_W) - 1) * MAX_ROWS + 1);
    localparam int SCORE_W     = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int GAIN_W      = CELL_W + 1;

    logic [RCNT_W-1:0]  rows_used;
    logic [CCNT_W-1:0]  cols_used;
    logic [RIDX_W-1:0]  rows_m1;
    logic [CIDX_W-1:0]  cols_m1;
    logic [LOAD_W-1:0]  size;

    logic [LOAD_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [RIDX_W-1:0]  r_reg, r_next;
    logic [GADDR_W-1:0] base_reg, base_next;
    logic [CIDX_W-1:0]  a_reg, a_next;
    logic [CIDX_W-1:0]  b_reg, b_next;
    logic               cur_reg, cur_next;
    logic               rvalid_reg, rvalid_next;

    logic [CELL_W-1:0]  cell_a_reg, cell_a_next;
    logic [CELL_W-1:0]  cell_b_reg, cell_b_next;
    logic [SCORE_W-1:0] acc_reg, acc_next;
    logic [SCORE_W-1:0] win_m_reg, win_m_next;
    logic [SCORE_W-1:0] win_r_reg, win_r_next;
    logic [SCORE_W-1:0] result_reg, result_next;

    logic               g_wr_en;
    logic               g_rd_en;
    logic [GADDR_W-1:0] g_rd_addr;
    logic [CELL_W-1:0]  g_rd_data;

    logic               s_wr_en;
    logic [SADDR_W-1:0] s_wr_addr;
    logic               s_rd_en;
    logic [SADDR_W-1:0] s_rd_addr;
    logic [SCORE_W-1:0] s_rd_data;

    logic [CIDX_W-1:0]  col_idx;
    logic [CIDX_W-1:0]  na;
    logic               col_ok;
    logic               a_lo_ok;
    logic               a_hi_ok;
    logic               bottom;
    logic               rd_ok;
    logic [SCORE_W-1:0] rd_val;
    logic [SCORE_W-1:0] new_col;
    logic [SCORE_W-1:0] best3;
    logic [GAIN_W-1:0]  gain;
    logic [SCORE_W-1:0] score_new;

    // out-of-range register values are clamped to the supported size
    always_comb
    begin
        if (row_count == '0)
        begin
            rows_used = RCNT_W'(1);
        end
        else if (32'(row_count) > MAX_ROWS)
        begin
            rows_used = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_used = RCNT_W'(row_count);
        end

        if (col_count == '0)
        begin
            cols_used = CCNT_W'(1);
        end
        else if (32'(col_count) > MAX_COLS)
        begin
            cols_used = CCNT_W'(MAX_COLS);
        end
        else
        begin
            cols_used = CCNT_W'(col_count);
        end
    end

    assign rows_m1 = RIDX_W'(rows_used - RCNT_W'(1));
    assign cols_m1 = CIDX_W'(cols_used - CCNT_W'(1));
    assign size    = LOAD_W'(LOAD_W'(rows_used) * LOAD_W'(cols_used));

    assign bottom  = (r_reg == rows_m1);
    assign col_idx = cmd.preload ? '0 : CIDX_W'(b_reg + CIDX_W'(1));
    assign col_ok  = cmd.preload || ((CCNT_W'(b_reg) + CCNT_W'(1)) < cols_used);
    assign a_lo_ok = (a_reg != '0);
    assign a_hi_ok = (CCNT_W'(a_reg) + CCNT_W'(1)) < cols_used;
    assign rd_ok   = !bottom && col_ok;

    // three rows of the column being fetched, one per phase
    always_comb
    begin
        na      = a_reg;
        s_rd_en = 1'b0;
        if (cmd.ph0)
        begin
            na      = CIDX_W'(a_reg - CIDX_W'(1));
            s_rd_en = rd_ok && a_lo_ok;
        end
        else if (cmd.ph1)
        begin
            s_rd_en = rd_ok;
        end
        else if (cmd.ph2)
        begin
            na      = CIDX_W'(a_reg + CIDX_W'(1));
            s_rd_en = rd_ok && a_hi_ok;
        end
    end

    assign s_rd_addr   = {cur_reg, na, col_idx};
    assign rvalid_next = s_rd_en;
    assign rd_val      = rvalid_reg ? s_rd_data : '0;
    assign new_col     = (rd_val > acc_reg) ? rd_val : acc_reg;

    always_comb
    begin
        best3 = (win_m_reg > win_r_reg) ? win_m_reg : win_r_reg;
        if (new_col > best3)
        begin
            best3 = new_col;
        end
    end

    assign gain      = (a_reg == b_reg) ? GAIN_W'(cell_a_reg)
                                        : GAIN_W'(cell_a_reg) + GAIN_W'(cell_b_reg);
    assign score_new = best3 + SCORE_W'(gain);

    assign s_wr_en   = cmd.ph3 && !cmd.preload;
    assign s_wr_addr = {~cur_reg, a_reg, b_reg};

    assign g_wr_en   = cmd.load && (load_cnt_reg < size);
    assign g_rd_en   = cmd.a_read || cmd.ph0;
    assign g_rd_addr = GADDR_W'(base_reg + GADDR_W'(cmd.a_read ? a_reg : b_reg));

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        r_next        = r_reg;
        base_next     = base_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;

        if (cmd.load)
        begin
            if (load_cnt_reg < size)
            begin
                load_cnt_next = load_cnt_reg + LOAD_W'(1);
            end
            else if (load_cnt_reg > size)
            begin
                load_cnt_next = size;
            end
            if (last_cell)
            begin
                load_cnt_next = '0;
            end
        end

        if (cmd.init)
        begin
            r_next    = rows_m1;
            base_next = GADDR_W'(size - LOAD_W'(cols_used));
            a_next    = '0;
            b_next    = '0;
            cur_next  = 1'b0;
        end
        else if (cmd.ph3 && !cmd.preload)
        begin
            if (b_reg != cols_m1)
            begin
                b_next = b_reg + CIDX_W'(1);
            end
            else
            begin
                b_next = '0;
                if (a_reg != cols_m1)
                begin
                    a_next = a_reg + CIDX_W'(1);
                end
                else
                begin
                    a_next    = '0;
                    r_next    = r_reg - RIDX_W'(1);
                    base_next = base_reg - GADDR_W'(cols_used);
                    cur_next  = ~cur_reg;
                end
            end
        end
    end

    always_comb
    begin
        cell_a_next = cell_a_reg;
        cell_b_next = cell_b_reg;
        acc_next    = acc_reg;
        win_m_next  = win_m_reg;
        win_r_next  = win_r_reg;
        result_next = result_reg;

        if (cmd.a_save)
        begin
            cell_a_next = g_rd_data;
            win_m_next  = '0;
            win_r_next  = '0;
        end
        if (cmd.ph1)
        begin
            cell_b_next = g_rd_data;
            acc_next    = rd_val;
        end
        if (cmd.ph2)
        begin
            acc_next = new_col;
        end
        if (cmd.ph3)
        begin
            win_m_next = win_r_reg;
            win_r_next = new_col;
            if (!cmd.preload && (r_reg == '0) && (a_reg == '0) && (b_reg == cols_m1))
            begin
                result_next = score_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            r_reg        <= '0;
            base_reg     <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            cur_reg      <= 1'b0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            r_reg        <= r_next;
            base_reg     <= base_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            cur_reg      <= cur_next;
            rvalid_reg   <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_a_reg <= cell_a_next;
        cell_b_reg <= cell_b_next;
        acc_reg    <= acc_next;
        win_m_reg  <= win_m_next;
        win_r_reg  <= win_r_next;
        result_reg <= result_next;
    end

    assign status.last_b   = (b_reg == cols_m1);
    assign status.last_a   = (a_reg == cols_m1);
    assign status.last_row = (r_reg == '0);
    assign best_total      = result_reg[TOTAL_W-1:0];

    twgmc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STORE_DEPTH)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (g_wr_en),
        .wr_addr (load_cnt_reg[GADDR_W-1:0]),
        .wr_data (cell_value),
        .rd_en   (g_rd_en),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data)
    );

    twgmc_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (SCORE_DEPTH)
    ) u_score_ram (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (score_new),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

endmodule

// ----- rtl/core/two_walker_grid_max_collect.sv -----
// Grid cells are written one per request (start high while busy is low) in row-major
// order; a plain request is only stored and busy stays low. A request with last_cell
// set raises busy and runs the two-walker table over the loaded grid. done is high for
// exactly one cycle, the last of the run, with best_total valid, and busy falls at the
// edge that ends that cycle. The receiver cannot stall: best_total must be taken in the
// cycle done is high. Each table entry passes through the phases P0 to P3 because the
// three entries of the row below are fetched one by one through the single read port
// of the score memory. Each first-walker column also passes through its own cell read
// (A_READ, A_SAVE) and a fetch of column 0 in P0 to P3. A run opens with a set-up state
// and closes with a result state. Cells beyond row_count*col_count are dropped, and
// row_count and col_count must only be written while busy is low.
module two_walker_grid_max_collect #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [twgmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [twgmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [twgmc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [twgmc_pkg::CELL_W-1:0]        cell_value,
    input  logic                                last_cell,
    output logic                                done,
    output logic [twgmc_pkg::TOTAL_W-1:0]       best_total
);

    import twgmc_pkg::*;

    logic [ROW_COUNT_W-1:0] row_count_reg, row_count_next;
    logic [COL_COUNT_W-1:0] col_count_reg, col_count_next;
    logic                   reg_wr;
    logic                   reg_sel;
    cmd_t                   cmd;
    status_t                status;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (reg_wr)
        begin
            case (reg_sel)
                REG_ROW_COUNT: row_count_next = pwdata[ROW_COUNT_W-1:0];
                REG_COL_COUNT: col_count_next = pwdata[COL_COUNT_W-1:0];
                default:       row_count_next = row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ROW_COUNT: prdata = APB_DATA_W'(row_count_reg);
            REG_COL_COUNT: prdata = APB_DATA_W'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    twgmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_cell (last_cell),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    twgmc_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .row_count  (row_count_reg),
        .col_count  (col_count_reg),
        .cell_value (cell_value),
        .last_cell  (last_cell),
        .status     (status),
        .best_total (best_total)
    );

endmodule

// ----- rtl/core/twgmc_checker.sv -----
module twgmc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_cell,
    input logic done
);

    // a request without last_cell is only stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_cell) |=> !busy)
        else $error("cell request left the block busy");

    // the closing request starts the table run
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_cell) |=> busy)
        else $error("last cell did not start the run");

    // one result per run, only while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy ##1 (!done && !busy)))
        else $error("result strobe not a single pulse at the end of a run");

    // a run ends only with its result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("run ended without a result");

endmodule

bind two_walker_grid_max_collect twgmc_checker u_twgmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_cell (last_cell),
    .done      (done)
);

// ----- tb/sv/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import twgmc_pkg::*;

    localparam int GRID_ROWS_MAX = 64;
    localparam int GRID_COLS_MAX = 16;
    localparam int STORE_DEPTH   = GRID_ROWS_MAX * GRID_COLS_MAX;
    localparam int RANDOM_CELLS  = 580;
    localparam int CYCLE_LIMIT   = 20000000;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   start;
    logic                   busy;
    logic [CELL_W-1:0]      cell_value;
    logic                   last_cell;
    logic                   done;
    logic [TOTAL_W-1:0]     best_total;

    // shadow of the block: grid memory, load pointer and size registers
    logic [CELL_W-1:0]      grid_mem [0:STORE_DEPTH-1];
    bit                     grid_written [0:STORE_DEPTH-1];
    int unsigned            load_cnt;
    logic [ROW_COUNT_W-1:0] row_reg;
    logic [COL_COUNT_W-1:0] col_reg;

    logic [TOTAL_W-1:0]     best_total_due [$];
    logic [TOTAL_W-1:0]     due_total;
    int unsigned            fault_count;
    int unsigned            cells_sent;
    int unsigned            burst_left;
    int unsigned            cycle_count;

    two_walker_grid_max_collect u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .cell_value (cell_value),
        .last_cell  (last_cell),
        .done       (done),
        .best_total (best_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL two_walker_grid_max_collect");
        $finish;
    end

    function automatic int unsigned rows_in_use();
        if (row_reg < 1)
            return 1;
        if (row_reg > GRID_ROWS_MAX)
            return GRID_ROWS_MAX;
        return 32'(row_reg);
    endfunction

    function automatic int unsigned cols_in_use();
        if (col_reg < 1)
            return 1;
        if (col_reg > GRID_COLS_MAX)
            return GRID_COLS_MAX;
        return 32'(col_reg);
    endfunction

    function automatic int unsigned cell_at(int unsigned r, int unsigned c, int unsigned cols);
        int unsigned k;
        k = r * cols + c;
        if (k >= STORE_DEPTH)
            return 0;
        return 32'(grid_mem[k]);
    endfunction

    // a cell shared by both walkers counts once
    function automatic int unsigned pair_gain(int unsigned r, int unsigned a, int unsigned b,
                                              int unsigned cols);
        if (a == b)
            return cell_at(r, a, cols);
        return cell_at(r, a, cols) + cell_at(r, b, cols);
    endfunction

    // bottom-up over rows, one entry per pair of walker columns
    function automatic logic [TOTAL_W-1:0] best_pair_total(int rows, int cols);
        int unsigned tier [0:1][0:GRID_COLS_MAX*GRID_COLS_MAX-1];
        int unsigned top;
        int cur;
        int nxt;
        int a;
        int b;
        int r;
        int da;
        int db;
        int na;
        int nb;
        cur = 0;
        for (a = 0; a < cols; a++)
            for (b = 0; b < cols; b++)
                tier[cur][a*GRID_COLS_MAX+b] = pair_gain(rows - 1, a, b, cols);
        for (r = rows - 1; r > 0; r--)
        begin
            nxt = cur ^ 1;
            for (a = 0; a < cols; a++)
            begin
                for (b = 0; b < cols; b++)
                begin
                    top = 0;
                    for (da = -1; da <= 1; da++)
                    begin
                        for (db = -1; db <= 1; db++)
                        begin
                            na = a + da;
                            nb = b + db;
                            if (na >= 0 && nb >= 0 && na < cols && nb < cols)
                                if (tier[cur][na*GRID_COLS_MAX+nb] > top)
                                    top = tier[cur][na*GRID_COLS_MAX+nb];
                        end
                    end
                    tier[nxt][a*GRID_COLS_MAX+b] = top + pair_gain(r - 1, a, b, cols);
                end
            end
            cur = nxt;
        end
        return TOTAL_W'(tier[cur][cols-1]);
    endfunction

    task automatic note_accepted(input logic [CELL_W-1:0] v, input logic last);
        int unsigned rows;
        int unsigned cols;
        int unsigned size;
        rows = rows_in_use();
        cols = cols_in_use();
        size = rows * cols;
        if (load_cnt < size)
        begin
            grid_mem[load_cnt] = v;
            grid_written[load_cnt] = 1'b1;
            load_cnt++;
            cells_sent++;
        end
        else if (load_cnt > size)
            load_cnt = size;
        if (last)
        begin
            best_total_due.push_back(best_pair_total(rows, cols));
            load_cnt = 0;
        end
    endtask

    task automatic pause_requests(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_cell(input logic [CELL_W-1:0] v, input logic last);
        start      <= 1'b1;
        cell_value <= v;
        last_cell  <= last;
        do
            @(posedge clk);
        while (busy);
        note_accepted(v, last);
    endtask

    // bursts of back-to-back requests, split by gaps of random length
    task automatic pace_after_request();
        if (burst_left != 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 7) == 0)
                pause_requests($urandom_range(15, 40));
            else
                pause_requests($urandom_range(1, 5));
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(0, 10);
        end
    endtask

    function automatic logic [CELL_W-1:0] pick_cell();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CELL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // n requests, the final one marked as the last cell; fixed < 0 means random values
    task automatic load_grid(input int unsigned n, input int fixed);
        logic [CELL_W-1:0] v;
        for (int unsigned i = 0; i < n; i++)
        begin
            v = (fixed < 0) ? pick_cell() : fixed[CELL_W-1:0];
            send_cell(v, i == n - 1);
            pace_after_request();
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (best_total_due.size() != 0 || busy)
            @(posedge clk);
        // allow the busy fall after the final strobe to settle
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROW_COUNT)
            row_reg = data[ROW_COUNT_W-1:0];
        else
            col_reg = data[COL_COUNT_W-1:0];
    endtask

    task automatic apb_check(input logic idx, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            fault_count++;
            $display("%0t: register %0d read expected %0d, got %0d", $time, idx, want, got);
        end
    endtask

    task automatic set_grid_size(input int unsigned rows_raw, input int unsigned cols_raw);
        logic [APB_DATA_W-1:0] rdata;
        logic [APB_DATA_W-1:0] cdata;
        wait_all_results();
        rdata = ($urandom() & ~32'h7F) | (rows_raw & 32'h7F);
        cdata = ($urandom() & ~32'h1F) | (cols_raw & 32'h1F);
        apb_write(REG_ROW_COUNT, rdata);
        apb_write(REG_COL_COUNT, cdata);
        apb_check(REG_ROW_COUNT, APB_DATA_W'(rdata[ROW_COUNT_W-1:0]));
        apb_check(REG_COL_COUNT, APB_DATA_W'(cdata[COL_COUNT_W-1:0]));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (best_total_due.size() == 0)
            begin
                fault_count++;
                $display("%0t: best_total expected none, got %0d", $time, best_total);
            end
            else
            begin
                due_total = best_total_due.pop_front();
                if (best_total !== due_total)
                begin
                    fault_count++;
                    $display("%0t: best_total expected %0d, got %0d",
                             $time, due_total, best_total);
                end
            end
        end
    end

    task automatic test_reset_registers();
        apb_check(REG_ROW_COUNT, APB_DATA_W'(ROW_COUNT_RST));
        apb_check(REG_COL_COUNT, APB_DATA_W'(COL_COUNT_RST));
    endtask

    task automatic test_single_cell();
        set_grid_size(1, 1);
        load_grid(1, 255);
        load_grid(1, 0);
    endtask

    task automatic test_single_column();
        set_grid_size(4, 1);
        load_grid(4, -1);
    endtask

    task automatic test_value_extremes();
        set_grid_size(3, 3);
        load_grid(9, 255);
        load_grid(9, 0);
        load_grid(9, -1);
    endtask

    // cells past the configured size are dropped, the last one too
    task automatic test_extra_cells();
        set_grid_size(2, 2);
        for (int i = 0; i < 6; i++)
            send_cell(pick_cell(), 1'b0);
        send_cell(pick_cell(), 1'b1);
        wait_all_results();
    endtask

    // a short grid reuses cells left by the earlier, complete one
    task automatic test_short_grid();
        set_grid_size(3, 3);
        load_grid(9, -1);
        load_grid(4, -1);
    endtask

    task automatic test_register_clamp();
        set_grid_size(0, 0);
        load_grid(1, -1);
        set_grid_size(127, 1);
        load_grid(GRID_ROWS_MAX, -1);
        set_grid_size(1, 31);
        load_grid(GRID_COLS_MAX, -1);
        set_grid_size(2, 16);
        load_grid(2 * GRID_COLS_MAX, -1);
    endtask

    task automatic test_random_grids();
        int unsigned sel;
        int unsigned size;
        int unsigned n;
        bit          reusable;
        cells_sent = 0;
        while (cells_sent < RANDOM_CELLS)
        begin
            if (cells_sent == 0 || $urandom_range(0, 3) == 0)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    set_grid_size($urandom_range(0, 127), $urandom_range(0, 3));
                else if (sel == 1)
                    set_grid_size($urandom_range(0, 4), $urandom_range(0, 31));
                else
                    set_grid_size($urandom_range(1, 8), $urandom_range(1, 8));
            end
            size = rows_in_use() * cols_in_use();
            sel = $urandom_range(0, 9);
            if (sel < 7)
                load_grid(size, -1);
            else if (sel == 7)
            begin
                for (int unsigned i = 0; i < size + $urandom_range(1, 5); i++)
                begin
                    send_cell(pick_cell(), 1'b0);
                    pace_after_request();
                end
                send_cell(pick_cell(), 1'b1);
                pace_after_request();
            end
            else
            begin
                // short grid only where every missing cell holds an earlier value
                n = $urandom_range(1, size);
                reusable = 1'b1;
                for (int unsigned k = n; k < size; k++)
                    if (!grid_written[k])
                        reusable = 1'b0;
                load_grid(reusable ? n : size, -1);
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        cell_value  = '0;
        last_cell   = 1'b0;
        load_cnt    = 0;
        row_reg     = ROW_COUNT_RST;
        col_reg     = COL_COUNT_RST;
        fault_count = 0;
        cells_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_single_cell();
        test_single_column();
        test_value_extremes();
        test_extra_cells();
        test_short_grid();
        test_register_clamp();
        test_random_grids();

        start <= 1'b0;
        while (best_total_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("PASS two_walker_grid_max_collect");
        else
            $display("FAIL two_walker_grid_max_collect");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/twgmc_pkg.sv
rtl/core/twgmc_ram.sv
rtl/core/twgmc_ctrl.sv
rtl/core/twgmc_dpath.sv
rtl/core/two_walker_grid_max_collect.sv
rtl/core/twgmc_checker.sv
tb/sv/tb.sv
